### hw/rtl/npc_pkg.sv
// Shared widths, constants and palette reset values for the nearest palette colour block.
package npc_pkg;

  localparam int NUM_COLORS_DEF = 8;
  localparam int PAL_REGS       = 8;
  localparam int PAL_SEL_W      = 3;
  localparam int CHAN_W         = 8;
  localparam int RGB_W          = 3 * CHAN_W;
  localparam int IDX_OUT_W      = 3;
  localparam int DIST_W         = 9;
  localparam int SQ_W           = 2 * DIST_W;
  localparam int CFG_IDX_W      = 4;
  localparam int MUL_CNT_W      = 3;
  localparam int MAX_DIST       = 441;

  localparam logic [RGB_W-1:0] PAL_RESET [PAL_REGS] = '{
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'hFF00FF, 24'h00FFFF, 24'hFFFFFF, 24'h000000
  };

endpackage

### hw/rtl/npc_if.sv
// Handshake interfaces for the sample, result and configuration channels.
interface npc_sample_if;
  import npc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface npc_result_if;
  import npc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] color_index;
  logic [DIST_W-1:0]    distance;
  modport source (output valid, color_index, distance, input ready);
  modport sink   (input valid, color_index, distance, output ready);
endinterface

interface npc_cfg_if;
  import npc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RGB_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/npc_sqr.sv
// Bit-serial squarer: one multiplier bit per cycle, eight shift-add steps per load.
module npc_sqr (
  input  logic                      clk,
  input  logic                      load,
  input  logic [npc_pkg::CHAN_W-1:0]   d,
  output logic [2*npc_pkg::CHAN_W-1:0] sq
);
  import npc_pkg::*;

  logic [2*CHAN_W-1:0] mcand;
  logic [CHAN_W-1:0]   mplier;
  logic [2*CHAN_W-1:0] acc;

  // Once the multiplier has shifted out, further steps add nothing.
  always_ff @(posedge clk) begin
    if (load) begin
      mcand  <= {{CHAN_W{1'b0}}, d};
      mplier <= d;
      acc    <= '0;
    end else begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[2*CHAN_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[CHAN_W-1:1]};
    end
  end

  assign sq = acc;

endmodule

### hw/rtl/npc_isqrt.sv
// Restoring integer square root, two radicand bits per cycle.
module npc_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [npc_pkg::SQ_W-1:0]  radicand,
  output logic                      done,
  output logic [npc_pkg::DIST_W-1:0] root
);
  import npc_pkg::*;

  localparam int REM_W = DIST_W + 1;
  localparam int CNT_W = $clog2(DIST_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W+1:0]  rem_trial;
  logic [DIST_W+1:0] trial;
  logic              ge;
  logic [REM_W-1:0]  rem_next;
  logic [DIST_W-1:0] root_next;

  always_comb begin
    rem_trial = {rem, rad[SQ_W-1 -: 2]};
    trial     = {root, 2'b01};
    ge        = rem_trial >= (REM_W+2)'(trial);
    rem_next  = ge ? REM_W'(rem_trial - (REM_W+2)'(trial)) : REM_W'(rem_trial);
    root_next = {root[DIST_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        root <= '0;
        rad  <= radicand;
      end else if (busy) begin
        rem  <= rem_next;
        root <= root_next;
        rad  <= {rad[SQ_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIST_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/nearest_palette_color.sv
// Top level: nearest palette colour by floor root of squared RGB distance.
//
//   channel  modport  moves
//   sample   sink     red, green, blue of one sample
//   result   source   color_index, distance of the nearest entry
//   cfg      sink     palette register index and 24-bit packed colour
//
// Each palette entry passes through a load, eight bit-serial squaring steps
// (three squarers in parallel), a sum, and nine root steps plus a done strobe in
// the shared root unit.
// Reset is synchronous and restores the default palette; there is no clearing pass.
// A finished result waits in the output register while the next sample is taken;
// only a second result finding it still full holds the sequencer.
module nearest_palette_color #(
  parameter int NUM_COLORS = npc_pkg::NUM_COLORS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  npc_sample_if.sink  sample,
  npc_result_if.source result,
  npc_cfg_if.sink     cfg
);
  import npc_pkg::*;

  localparam int IDX_W = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_SUM, S_ROOT, S_OUT
  } state_t;

  state_t                 state;
  logic [IDX_W-1:0]       k;
  logic [MUL_CNT_W-1:0]   cnt;
  logic [RGB_W-1:0]       palette [PAL_REGS];
  logic [CHAN_W-1:0]      s_red, s_green, s_blue;
  logic [IDX_W-1:0]       best_idx;
  logic [DIST_W-1:0]      best_dist;

  logic [RGB_W-1:0]       pal;
  logic [CHAN_W-1:0]      d_red, d_green, d_blue;
  logic [2*CHAN_W-1:0]    sq_red, sq_green, sq_blue;
  logic [SQ_W-1:0]        sq_sum;
  logic                   sq_load;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [DIST_W-1:0]      root;
  logic                   last;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    pal        = palette[PAL_SEL_W'(k)];
    d_red      = abs_diff(pal[3*CHAN_W-1 -: CHAN_W], s_red);
    d_green    = abs_diff(pal[2*CHAN_W-1 -: CHAN_W], s_green);
    d_blue     = abs_diff(pal[CHAN_W-1:0], s_blue);
    sq_sum     = SQ_W'(sq_red) + SQ_W'(sq_green) + SQ_W'(sq_blue);
    sq_load    = state == S_LOAD;
    sqrt_start = state == S_SUM;
    last       = k == IDX_W'(NUM_COLORS - 1);
  end

  npc_sqr u_sqr_red   (.clk(clk), .load(sq_load), .d(d_red),   .sq(sq_red));
  npc_sqr u_sqr_green (.clk(clk), .load(sq_load), .d(d_green), .sq(sq_green));
  npc_sqr u_sqr_blue  (.clk(clk), .load(sq_load), .d(d_blue),  .sq(sq_blue));

  npc_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(sq_sum),
    .done(sqrt_done), .root(root)
  );

  assign sample.ready = state == S_IDLE;
  assign cfg.ready    = 1'b1;

  // Palette registers; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAL_REGS; i++) begin
        palette[i] <= PAL_RESET[i];
      end
    end else if (cfg.valid && cfg.index < CFG_IDX_W'(PAL_REGS)) begin
      palette[PAL_SEL_W'(cfg.index)] <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      // In the output state a taken result is replaced by the new one below.
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            s_red   <= sample.red;
            s_green <= sample.green;
            s_blue  <= sample.blue;
            k       <= '0;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == MUL_CNT_W'(CHAN_W - 1)) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sqrt_done) begin
            // Only a strictly smaller root displaces the best so far.
            if (k == '0 || root < best_dist) begin
              best_idx  <= k;
              best_dist <= root;
            end
            if (last) begin
              state <= S_OUT;
            end else begin
              k     <= k + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.color_index <= IDX_OUT_W'(best_idx);
            result.distance    <= best_dist;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_root: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_ROOT)
    else $error("root unit finished outside the root phase");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> state == S_LOAD && k == '0)
    else $error("accepted sample did not start at palette entry zero");

  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.distance <= DIST_W'(MAX_DIST))
    else $error("result distance beyond the largest possible root");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.color_index <= IDX_OUT_W'(NUM_COLORS - 1))
    else $error("result index beyond the active palette");
`endif

endmodule
